### rtl/oahs_pkg.sv
// shared widths, reset values, register codes and types of the adc smoother
`default_nettype none

package oahs_pkg;

  // payload widths
  localparam int unsigned CHANNEL_W = 3;
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned LEVEL_W   = 20;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned GAIN_W    = 16;

  // default sizing
  localparam int unsigned OVERSAMPLE_COUNT_DEF = 8;
  localparam int unsigned CHANNEL_COUNT_DEF    = 8;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEADBAND   = 2'd0,
    CFG_POT_GAIN   = 2'd1,
    CFG_CV_GAIN    = 2'd2,
    CFG_CV_CHANNEL = 2'd3
  } cfg_index_t;

  // register reset values
  localparam logic [SAMPLE_W-1:0]  DEADBAND_RST   = 12'd8;
  localparam logic [GAIN_W-1:0]    POT_GAIN_RST   = 16'd6554;
  localparam logic [GAIN_W-1:0]    CV_GAIN_RST    = 16'd6554;
  localparam logic [CHANNEL_W-1:0] CV_CHANNEL_RST = 3'd6;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  deadband_threshold;
    logic [GAIN_W-1:0]    pot_filter_gain;
    logic [GAIN_W-1:0]    cv_filter_gain;
    logic [CHANNEL_W-1:0] cv_channel_number;
  } cfg_t;

  // one finished average on its way to the filter
  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [SAMPLE_W-1:0]  average;
  } avg_t;

endpackage

`default_nettype wire

### rtl/oahs_if.sv
// valid/ready channel interfaces for conversions and filtered results
`default_nettype none

interface oahs_conv_if;
  logic                             valid;
  logic                             ready;
  logic [oahs_pkg::CHANNEL_W-1:0]   channel;
  logic [oahs_pkg::SAMPLE_W-1:0]    sample;
  logic                             discard;

  modport source (output valid, channel, sample, discard, input ready);
  modport sink   (input valid, channel, sample, discard, output ready);
endinterface

interface oahs_result_if;
  logic                             valid;
  logic                             ready;
  logic [oahs_pkg::CHANNEL_W-1:0]   out_channel;
  logic [oahs_pkg::SAMPLE_W-1:0]    average;
  logic [oahs_pkg::LEVEL_W-1:0]     level;
  logic                             held;

  modport source (output valid, out_channel, average, level, held, input ready);
  modport sink   (input valid, out_channel, average, level, held, output ready);
endinterface

`default_nettype wire

### rtl/oahs_average.sv
// input register, oversample accumulator and truncated mean stage
`default_nettype none

module oahs_average #(
  parameter int unsigned OVERSAMPLE_COUNT = oahs_pkg::OVERSAMPLE_COUNT_DEF,
  parameter int unsigned CHANNEL_COUNT    = oahs_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  oahs_conv_if.sink          conv,
  output oahs_pkg::avg_t     avg_data,
  output logic               avg_valid,
  input  wire logic          avg_ready
);

  localparam int unsigned LOG_N   = $clog2(OVERSAMPLE_COUNT);
  localparam int unsigned SUM_W   = oahs_pkg::SAMPLE_W + LOG_N;
  localparam int unsigned CNT_W   = (OVERSAMPLE_COUNT > 1) ? LOG_N : 1;
  localparam int unsigned PROD_W  = 2 * SUM_W + 1;
  localparam int unsigned DIV_SHIFT = SUM_W + LOG_N;
  localparam longint unsigned DIV_MULT_L =
    ((64'd1 << DIV_SHIFT) + OVERSAMPLE_COUNT - 1) / OVERSAMPLE_COUNT;
  localparam logic [SUM_W:0]  DIV_MULT  = DIV_MULT_L[SUM_W:0];
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OVERSAMPLE_COUNT - 1);
  localparam logic [oahs_pkg::CHANNEL_W:0] CH_LIMIT =
    (oahs_pkg::CHANNEL_W + 1)'(CHANNEL_COUNT);

  // input register
  logic                             in_valid;
  logic [oahs_pkg::CHANNEL_W-1:0]   in_channel;
  logic [oahs_pkg::SAMPLE_W-1:0]    in_sample;
  logic                             in_discard;

  // accumulator state
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic              stage_free;
  logic              consume;
  logic              done;
  logic [SUM_W-1:0]  sum_add;
  logic [PROD_W-1:0] quot_prod;
  logic [oahs_pkg::SAMPLE_W-1:0] mean;

  assign stage_free = !avg_valid || avg_ready;
  assign conv.ready = !in_valid || stage_free;
  assign consume    = in_valid && stage_free;

  // truncated mean by reciprocal multiply, exact over the whole sum range
  assign sum_add   = sum + SUM_W'(in_sample);
  assign quot_prod = PROD_W'(sum_add) * PROD_W'(DIV_MULT);
  assign mean      = quot_prod[DIV_SHIFT +: oahs_pkg::SAMPLE_W];

  // accumulator update for the item leaving the input register
  always_comb begin
    sum_next   = sum;
    count_next = count;
    done       = 1'b0;
    if (consume) begin
      if (in_discard) begin
        sum_next   = '0;
        count_next = '0;
      end else if ({1'b0, in_channel} < CH_LIMIT) begin
        if (count == CNT_LAST) begin
          sum_next   = '0;
          count_next = '0;
          done       = 1'b1;
        end else begin
          sum_next   = sum_add;
          count_next = count + CNT_W'(1);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      avg_valid <= 1'b0;
      sum       <= '0;
      count     <= '0;
    end else begin
      sum   <= sum_next;
      count <= count_next;
      if (conv.ready) begin
        in_valid <= conv.valid;
      end
      if (stage_free) begin
        avg_valid <= done;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (conv.ready) begin
      in_channel <= conv.channel;
      in_sample  <= conv.sample;
      in_discard <= conv.discard;
    end
    if (stage_free) begin
      avg_data.channel <= in_channel;
      avg_data.average <= mean;
    end
  end

endmodule

`default_nettype wire

### rtl/oahs_filter.sv
// deadband check, per-channel exponential filter and result register
`default_nettype none

module oahs_filter #(
  parameter int unsigned CHANNEL_COUNT = oahs_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire oahs_pkg::cfg_t  cfg,
  input  wire oahs_pkg::avg_t  avg_data,
  input  wire logic            avg_valid,
  output logic                 avg_ready,
  oahs_result_if.source        result
);

  localparam int unsigned IDX_W  = $clog2(CHANNEL_COUNT);
  localparam int unsigned LVL_W  = oahs_pkg::LEVEL_W;
  localparam int unsigned SMP_W  = oahs_pkg::SAMPLE_W;
  localparam int unsigned PROD_W = oahs_pkg::GAIN_W + LVL_W;

  // per-channel state
  logic [SMP_W-1:0] last_accepted [CHANNEL_COUNT];
  logic [LVL_W-1:0] filtered_level [CHANNEL_COUNT];

  // result register
  logic                           out_valid;
  logic [oahs_pkg::CHANNEL_W-1:0] out_channel;
  logic [SMP_W-1:0]               out_average;
  logic [LVL_W-1:0]               out_level;
  logic                           out_held;

  logic                       take;
  logic [IDX_W-1:0]           idx;
  logic [SMP_W-1:0]           last;
  logic [LVL_W-1:0]           lvl;
  logic                       is_cv;
  logic [SMP_W-1:0]           delta;
  logic                       held;
  logic [SMP_W-1:0]           value;
  logic [oahs_pkg::GAIN_W-1:0] gain;
  logic [LVL_W-1:0]           target;
  logic                       rising;
  logic [LVL_W-1:0]           span;
  logic [PROD_W-1:0]          step_prod;
  logic [LVL_W-1:0]           step;
  logic [LVL_W-1:0]           level_next;

  assign avg_ready = !out_valid || result.ready;
  assign take      = avg_valid && avg_ready;

  assign idx   = avg_data.channel[IDX_W-1:0];
  assign last  = last_accepted[idx];
  assign lvl   = filtered_level[idx];
  assign is_cv = avg_data.channel == cfg.cv_channel_number;

  // deadband against the last accepted pot value
  assign delta = (avg_data.average >= last) ? avg_data.average - last
                                            : last - avg_data.average;
  assign held  = !is_cv && (delta < cfg.deadband_threshold);
  assign value = held ? last : avg_data.average;
  assign gain  = is_cv ? cfg.cv_filter_gain : cfg.pot_filter_gain;

  // one exponential step toward the target, never past it
  assign target     = {value, {oahs_pkg::FRAC_W{1'b0}}};
  assign rising     = target >= lvl;
  assign span       = rising ? target - lvl : lvl - target;
  assign step_prod  = PROD_W'(gain) * PROD_W'(span);
  assign step       = step_prod[PROD_W-1 -: LVL_W];
  assign level_next = rising ? lvl + step : lvl - step;

  // channel state, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        last_accepted[i]  <= '0;
        filtered_level[i] <= '0;
      end
    end else if (take) begin
      filtered_level[idx] <= level_next;
      if (!is_cv && !held) begin
        last_accepted[idx] <= avg_data.average;
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (avg_ready) begin
      out_valid <= avg_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_channel <= avg_data.channel;
      out_average <= avg_data.average;
      out_level   <= level_next;
      out_held    <= held;
    end
  end

  assign result.valid       = out_valid;
  assign result.out_channel = out_channel;
  assign result.average     = out_average;
  assign result.level       = out_level;
  assign result.held        = out_held;

endmodule

`default_nettype wire

### rtl/oversampled_adc_hysteresis_smoother_core.sv
// Oversampled converter smoother: each conversion transaction lands in an input
// register; the next stage adds it to the oversample sum and, on the last kept
// conversion of a block, forms the truncated mean with a reciprocal multiply;
// the stage after that applies the pot deadband and one exponential filter
// step for the channel and loads the result register. A new conversion is
// taken every cycle unless the result side stalls; a block's result leaves
// through the input, average and result registers. The rate is set by the
// per-channel filter read-modify-write. Discarded conversions and conversions
// on channels at or above CHANNEL_COUNT produce no result. Configuration is to
// be written only while the block is idle; the block does not enforce this.
`default_nettype none

module oversampled_adc_hysteresis_smoother_core #(
  parameter int unsigned OVERSAMPLE_COUNT = oahs_pkg::OVERSAMPLE_COUNT_DEF,
  parameter int unsigned CHANNEL_COUNT    = oahs_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [oahs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [oahs_pkg::CFG_DATA_W-1:0]   cfg_data,
  oahs_conv_if.sink                              conv,
  oahs_result_if.source                          result
);

  oahs_pkg::cfg_t cfg;
  oahs_pkg::avg_t avg_data;
  logic           avg_valid;
  logic           avg_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband_threshold <= oahs_pkg::DEADBAND_RST;
      cfg.pot_filter_gain    <= oahs_pkg::POT_GAIN_RST;
      cfg.cv_filter_gain     <= oahs_pkg::CV_GAIN_RST;
      cfg.cv_channel_number  <= oahs_pkg::CV_CHANNEL_RST;
    end else if (cfg_write) begin
      case (oahs_pkg::cfg_index_t'(cfg_index))
        oahs_pkg::CFG_DEADBAND:   cfg.deadband_threshold <= cfg_data[oahs_pkg::SAMPLE_W-1:0];
        oahs_pkg::CFG_POT_GAIN:   cfg.pot_filter_gain    <= cfg_data[oahs_pkg::GAIN_W-1:0];
        oahs_pkg::CFG_CV_GAIN:    cfg.cv_filter_gain     <= cfg_data[oahs_pkg::GAIN_W-1:0];
        oahs_pkg::CFG_CV_CHANNEL: cfg.cv_channel_number  <= cfg_data[oahs_pkg::CHANNEL_W-1:0];
        default: ;
      endcase
    end
  end

  // oversample sum and mean
  oahs_average #(
    .OVERSAMPLE_COUNT (OVERSAMPLE_COUNT),
    .CHANNEL_COUNT    (CHANNEL_COUNT)
  ) u_average (
    .clk       (clk),
    .rst       (rst),
    .conv      (conv),
    .avg_data  (avg_data),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready)
  );

  // deadband and exponential filter
  oahs_filter #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_filter (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .avg_data  (avg_data),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .result    (result)
  );

endmodule

`default_nettype wire
